[hw/rtl/mcma_pkg.sv]
// Package for the multi-channel moving average block.
// Holds field widths, defaults, codes and the command type shared by the modules that import it.
// No dependencies.
`default_nettype none

package mcma_pkg;

  // Fixed field widths
  localparam int DATA_W    = 16;
  localparam int CH_W      = 2;
  localparam int LEN_W     = 5;
  localparam int NUM_REGS  = 3;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF = 16;
  localparam int CHANNELS_DEF   = 3;

  // Depth of the queue between the front and the back
  localparam int FIFO_DEPTH = 2;

  typedef logic [LEN_W-1:0] len_reg_t;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_PRIME  = 1'b1
  } mode_t;

  // One classified item on its way to the back
  typedef struct packed {
    mode_t             mode;
    logic [CH_W-1:0]   chan;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIME,
    ST_WRITE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/mcma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mcma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/mcma_front.sv]
// Front end: accepts input beats, drops beats for absent channels, queues commands.
// Depends on mcma_pkg.
`default_nettype none

module mcma_front #(
  parameter int CHANNELS = mcma_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clearing,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mcma_pkg::DATA_W-1:0] s_axis_tdata,
  input  logic [mcma_pkg::CH_W:0]     s_axis_tuser,
  output logic                        cmd_valid,
  output mcma_pkg::cmd_t              cmd,
  input  logic                        cmd_ready
);
  import mcma_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             q_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             push;
  logic             pop;
  cmd_t             in_cmd;

  // Classify the incoming beat
  assign in_cmd.mode  = mode_t'(s_axis_tuser[0]);
  assign in_cmd.chan  = s_axis_tuser[CH_W:1];
  assign in_cmd.value = s_axis_tdata;

  assign s_axis_tready = !clearing && (count != CNT_W'(FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && (int'(in_cmd.chan) < CHANNELS);
  assign pop           = cmd_valid && cmd_ready;

  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= in_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mcma_divider.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on mcma_pkg.
`default_nettype none

module mcma_divider #(
  parameter int SUM_W = 21,
  parameter int DIV_W = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [mcma_pkg::DATA_W-1:0] quotient
);
  import mcma_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic              neg;
  logic [SUM_W-1:0]  dvd;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    rem_shift;
  logic              ge;

  // One restoring step
  assign rem_shift = {rem, dvd[SUM_W-1]};
  assign ge        = (rem_shift >= {1'b0, dsr});

  // Apply the sign to the magnitude quotient
  assign quotient = DATA_W'(neg ? (~dvd + 1'b1) : dvd);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(SUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      dvd <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DIV_W'(rem_shift - {1'b0, dsr}) : rem_shift[DIV_W-1:0];
      dvd <= {dvd[SUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mcma_back.sv]
// Back end: sequencer over the sample RAM, window sum sweep, divider and output register.
// Depends on mcma_pkg, mcma_ram and mcma_divider.
`default_nettype none

module mcma_back #(
  parameter int MAX_WINDOW = mcma_pkg::MAX_WINDOW_DEF,
  parameter int CHANNELS   = mcma_pkg::CHANNELS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  mcma_pkg::len_reg_t [mcma_pkg::NUM_REGS-1:0] win_len,
  input  logic                                        cmd_valid,
  input  mcma_pkg::cmd_t                              cmd,
  output logic                                        cmd_ready,
  output logic                                        clearing,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [mcma_pkg::DATA_W-1:0]                 m_axis_tdata,
  output logic [mcma_pkg::CH_W-1:0]                   m_axis_tuser
);
  import mcma_pkg::*;

  localparam int DEPTH  = CHANNELS * MAX_WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CSEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W  = DATA_W + $clog2(MAX_WINDOW) + 1;

  back_state_t       state;
  back_state_t       state_next;

  logic [IDX_W-1:0]  widx [CHANNELS];
  logic [ADDR_W-1:0] clr_addr;
  logic [CH_W-1:0]   chan_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  len_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  acc;
  logic              rd_vld;
  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  idx_wrap;
  logic [SUM_W-1:0]  rd_ext;
  logic [SUM_W-1:0]  sum_total;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              out_load;

  // Effective window length of the channel at the queue head
  always_comb begin
    if (int'(cmd.chan) >= NUM_REGS) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else if (win_len[cmd.chan] == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(win_len[cmd.chan]) > MAX_WINDOW) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(win_len[cmd.chan]);
    end
  end

  // Write index after this sample, wrapped at the window length
  assign idx_inc  = CNT_W'(idx_q) + 1'b1;
  assign idx_wrap = (idx_inc >= len_q) ? '0 : IDX_W'(idx_inc);

  assign rd_ext    = {{(SUM_W - DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
  assign sum_total = acc + rd_ext;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.mode == MODE_PRIME) ? ST_PRIME : ST_WRITE;
        end
      end
      ST_PRIME: if (cnt == len_q - 1'b1) state_next = ST_IDLE;
      ST_WRITE: state_next = ST_READ;
      ST_READ:  if (cnt == len_q - 1'b1) state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = val_q;
    ram_raddr = ADDR_W'(int'(chan_q) * MAX_WINDOW + int'(cnt));
    cmd_ready = 1'b0;
    clearing  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_IDLE:  cmd_ready = 1'b1;
      ST_PRIME: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(int'(chan_q) * MAX_WINDOW + int'(cnt));
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(int'(chan_q) * MAX_WINDOW + int'(idx_q));
      end
      ST_READ:  ;
      ST_SUM:   div_start = 1'b1;
      ST_DIV:   ;
      ST_DONE:  out_load = !m_axis_tvalid || m_axis_tready;
      default:  ;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_vld   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        widx[c] <= '0;
      end
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_READ);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_WRITE) begin
        widx[CSEL_W'(chan_q)] <= idx_wrap;
      end
      if (state == ST_PRIME && cnt == len_q - 1'b1) begin
        widx[CSEL_W'(chan_q)] <= '0;
      end
    end
  end

  // Latch the command and run the counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      chan_q <= cmd.chan;
      val_q  <= cmd.value;
      len_q  <= eff_len;
      idx_q  <= widx[CSEL_W'(cmd.chan)];
    end
    if (state == ST_PRIME || state == ST_READ) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
    if (state == ST_WRITE) begin
      acc <= '0;
    end else if (rd_vld) begin
      acc <= sum_total;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= div_q;
      m_axis_tuser <= chan_q;
    end
  end

  mcma_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mcma_divider #(
    .SUM_W(SUM_W),
    .DIV_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_total),
    .divisor (len_q),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

`default_nettype wire

[hw/rtl/multi_channel_moving_average.sv]
// Channel    | Dir | Payload
// s_axis     | in  | tdata[15:0] sample_value; tuser[0] mode, tuser[2:1] channel
// m_axis     | out | tdata[15:0] average; tuser[1:0] out_channel
// cfg        | in  | cfg_we, cfg_index[1:0], cfg_data[4:0] window length per channel
//
// A sample item makes len window reads of the sample RAM, then runs a
// one-bit-per-cycle divider over the 21-bit window sum; a prime item writes len words.
// After reset the sample RAM is zeroed, all CHANNELS * MAX_WINDOW words (48 by default);
// s_axis_tready stays low during that pass. A two-entry queue decouples input from the
// sequencer, and the output register lets the next item run while a result waits.
// Depends on mcma_pkg, mcma_front, mcma_back.
`default_nettype none

module multi_channel_moving_average #(
  parameter int MAX_WINDOW = mcma_pkg::MAX_WINDOW_DEF,
  parameter int CHANNELS   = mcma_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mcma_pkg::DATA_W-1:0]    s_axis_tdata,   // [15:0] sample_value
  input  logic [mcma_pkg::CH_W:0]        s_axis_tuser,   // [0] mode, [2:1] channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mcma_pkg::DATA_W-1:0]    m_axis_tdata,   // [15:0] average
  output logic [mcma_pkg::CH_W-1:0]      m_axis_tuser,   // [1:0] out_channel
  input  logic                           cfg_we,
  input  logic [mcma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcma_pkg::LEN_W-1:0]     cfg_data
);
  import mcma_pkg::*;

  len_reg_t [NUM_REGS-1:0] win_len;
  logic                    clearing;
  logic                    cmd_valid;
  logic                    cmd_ready;
  cmd_t                    cmd;

  // Window length registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        win_len[r] <= LEN_W'(16);
      end
    end else if (cfg_we && int'(cfg_index) < NUM_REGS) begin
      win_len[cfg_index] <= cfg_data;
    end
  end

  mcma_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready)
  );

  mcma_back #(
    .MAX_WINDOW(MAX_WINDOW),
    .CHANNELS  (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .win_len      (win_len),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .clearing     (clearing),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/mcma_checker.sv]
// Port-level checks for the moving average block, bound to the top level.
// Depends on mcma_pkg and multi_channel_moving_average.
`default_nettype none

module mcma_checker #(
  parameter int CHANNELS = mcma_pkg::CHANNELS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mcma_pkg::DATA_W-1:0]    m_axis_tdata,
  input logic [mcma_pkg::CH_W-1:0]      m_axis_tuser
);
  import mcma_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Results only name existing channels
  a_out_chan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> int'(m_axis_tuser) < CHANNELS)
    else $error("result for a channel that does not exist");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // Input is closed at the start of the RAM clearing pass after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input open during the clearing pass");

endmodule

bind multi_channel_moving_average mcma_checker #(
  .CHANNELS(CHANNELS)
) u_mcma_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
